// ===== sv/gdr_pkg.sv =====
// Shared types, constants and codes of the grid DDA ray caster.
package gdr_pkg;

  // Defaults of the top level parameters
  localparam int DEF_MAP_WIDTH  = 64;
  localparam int DEF_MAP_HEIGHT = 64;
  localparam int DEF_MAX_SCREEN = 2048;
  localparam int DEF_CELL_BITS  = 4;

  // Field widths
  localparam int CODE_W  = 4;
  localparam int DIR_W   = 16;
  localparam int EYE_W   = 18;
  localparam int FRAC_W  = 12;
  localparam int SCR_W   = 12;
  localparam int COL_W   = 11;
  localparam int CELLI_W = 6;
  localparam int CFG_DW  = 18;
  localparam int CFG_IW  = 3;

  // Internal widths
  localparam int CW      = 10;   // signed cell coordinate, -1 .. 256
  localparam int RAY_W   = 18;
  localparam int AD_W    = 17;
  localparam int DELTA_W = 31;
  localparam int RUN_W   = 40;
  localparam int NUM_W   = 22;
  localparam int DIST_W  = 22;
  localparam int LINE_W  = 16;
  localparam int DIV_NW  = 36;
  localparam int DIV_DW  = 22;

  localparam logic [CODE_W-1:0]  BORDER_CODE = 4'd15;
  localparam logic [DELTA_W-1:0] STEP_SAT    = 31'h4000_0000;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 22'h3F_FFFF;
  localparam logic [LINE_W-1:0]  LINE_MAX    = 16'hFFFF;

  // Register reset values
  localparam logic [DIR_W-1:0] RST_CAM_DIR_X = 16'd16384;
  localparam logic [DIR_W-1:0] RST_CAM_DIR_Y = 16'd0;
  localparam logic [DIR_W-1:0] RST_PLANE_X   = 16'd0;
  localparam logic [DIR_W-1:0] RST_PLANE_Y   = 16'd10813;
  localparam logic [EYE_W-1:0] RST_EYE_X     = 18'd8192;
  localparam logic [EYE_W-1:0] RST_EYE_Y     = 18'd8192;
  localparam logic [SCR_W-1:0] RST_WIDTH     = 12'd640;
  localparam logic [SCR_W-1:0] RST_HEIGHT    = 12'd480;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CAM_DIR_X = 3'd0,
    CFG_CAM_DIR_Y = 3'd1,
    CFG_PLANE_X   = 3'd2,
    CFG_PLANE_Y   = 3'd3,
    CFG_EYE_X     = 3'd4,
    CFG_EYE_Y     = 3'd5,
    CFG_WIDTH     = 3'd6,
    CFG_HEIGHT    = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_CAM,
    DIV_DX,
    DIV_DY,
    DIV_DIST,
    DIV_LH
  } div_op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM_GO,
    ST_CAM_WAIT,
    ST_RAY_MUL,
    ST_RAY_SUM,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_DY_GO,
    ST_DY_WAIT,
    ST_SETUP,
    ST_STEP,
    ST_CHECK,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_LH_GO,
    ST_LH_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    accept;
    logic    div_start;
    div_op_t div_op;
    logic    ray_mul;
    logic    ray_sum;
    logic    setup;
    logic    step;
    logic    check;
    logic    finish;
  } gdr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic walk_end;
    logic out_free;
  } gdr_status_t;

endpackage

// ===== sv/gdr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module gdr_div #(
  parameter int NW = gdr_pkg::DIV_NW,
  parameter int DW = gdr_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt;
  logic            running;
  logic [DW:0]     trial;

  assign trial = {rem, q[NW-1]} - {1'b0, den_r};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNTW'(NW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num;
      rem   <= '0;
      den_r <= den;
    end else if (running) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-2:0], q[NW-1]};
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/gdr_ctrl.sv =====
// Sequencer of the ray caster: clear sweep, cast setup, DDA walk, distance, span.
module gdr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 action,
  input  gdr_pkg::gdr_status_t st,
  output gdr_pkg::gdr_cmd_t    cmd
);

  gdr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gdr_pkg::ST_CLEAR:     if (st.clear_last) state_next = gdr_pkg::ST_IDLE;
      gdr_pkg::ST_IDLE:      if (in_valid && action) state_next = gdr_pkg::ST_CAM_GO;
      gdr_pkg::ST_CAM_GO:    state_next = gdr_pkg::ST_CAM_WAIT;
      gdr_pkg::ST_CAM_WAIT:  if (st.div_done) state_next = gdr_pkg::ST_RAY_MUL;
      gdr_pkg::ST_RAY_MUL:   state_next = gdr_pkg::ST_RAY_SUM;
      gdr_pkg::ST_RAY_SUM:   state_next = gdr_pkg::ST_DX_GO;
      gdr_pkg::ST_DX_GO:     state_next = gdr_pkg::ST_DX_WAIT;
      gdr_pkg::ST_DX_WAIT:   if (st.div_done) state_next = gdr_pkg::ST_DY_GO;
      gdr_pkg::ST_DY_GO:     state_next = gdr_pkg::ST_DY_WAIT;
      gdr_pkg::ST_DY_WAIT:   if (st.div_done) state_next = gdr_pkg::ST_SETUP;
      gdr_pkg::ST_SETUP:     state_next = gdr_pkg::ST_STEP;
      gdr_pkg::ST_STEP:      state_next = gdr_pkg::ST_CHECK;
      gdr_pkg::ST_CHECK: begin
        state_next = st.walk_end ? gdr_pkg::ST_DIST_GO : gdr_pkg::ST_STEP;
      end
      gdr_pkg::ST_DIST_GO:   state_next = gdr_pkg::ST_DIST_WAIT;
      gdr_pkg::ST_DIST_WAIT: if (st.div_done) state_next = gdr_pkg::ST_LH_GO;
      gdr_pkg::ST_LH_GO:     state_next = gdr_pkg::ST_LH_WAIT;
      gdr_pkg::ST_LH_WAIT:   if (st.div_done) state_next = gdr_pkg::ST_FINISH;
      gdr_pkg::ST_FINISH:    if (st.out_free) state_next = gdr_pkg::ST_IDLE;
      default:               state_next = gdr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = gdr_pkg::DIV_NONE;
    case (state)
      gdr_pkg::ST_CLEAR:     cmd.clear = 1'b1;
      gdr_pkg::ST_IDLE:      cmd.accept = 1'b1;
      gdr_pkg::ST_CAM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = gdr_pkg::DIV_CAM;
      end
      gdr_pkg::ST_CAM_WAIT:  cmd.div_op = gdr_pkg::DIV_CAM;
      gdr_pkg::ST_RAY_MUL:   cmd.ray_mul = 1'b1;
      gdr_pkg::ST_RAY_SUM:   cmd.ray_sum = 1'b1;
      gdr_pkg::ST_DX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = gdr_pkg::DIV_DX;
      end
      gdr_pkg::ST_DX_WAIT:   cmd.div_op = gdr_pkg::DIV_DX;
      gdr_pkg::ST_DY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = gdr_pkg::DIV_DY;
      end
      gdr_pkg::ST_DY_WAIT:   cmd.div_op = gdr_pkg::DIV_DY;
      gdr_pkg::ST_SETUP:     cmd.setup = 1'b1;
      gdr_pkg::ST_STEP:      cmd.step = 1'b1;
      gdr_pkg::ST_CHECK:     cmd.check = 1'b1;
      gdr_pkg::ST_DIST_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = gdr_pkg::DIV_DIST;
      end
      gdr_pkg::ST_DIST_WAIT: cmd.div_op = gdr_pkg::DIV_DIST;
      gdr_pkg::ST_LH_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = gdr_pkg::DIV_LH;
      end
      gdr_pkg::ST_LH_WAIT:   cmd.div_op = gdr_pkg::DIV_LH;
      gdr_pkg::ST_FINISH:    cmd.finish = 1'b1;
      default:               cmd.clear = 1'b0;
    endcase
  end

endmodule

// ===== sv/gdr_datapath.sv =====
// Datapath of the ray caster: registers, map memory, walk arithmetic, result register.
module gdr_datapath #(
  parameter int MAP_WIDTH  = gdr_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = gdr_pkg::DEF_MAP_HEIGHT,
  parameter int MAX_SCREEN = gdr_pkg::DEF_MAX_SCREEN,
  parameter int CELL_BITS  = gdr_pkg::DEF_CELL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gdr_pkg::gdr_cmd_t             cmd,
  output gdr_pkg::gdr_status_t          st,
  input  logic                          cfg_write,
  input  logic [gdr_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [gdr_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          action,
  input  logic [gdr_pkg::CELLI_W-1:0]   cell_x,
  input  logic [gdr_pkg::CELLI_W-1:0]   cell_y,
  input  logic [gdr_pkg::CODE_W-1:0]    cell_code,
  input  logic [gdr_pkg::COL_W-1:0]     column,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [gdr_pkg::COL_W-1:0]     out_column,
  output logic                          side,
  output logic [gdr_pkg::CELLI_W-1:0]   hit_x,
  output logic [gdr_pkg::CELLI_W-1:0]   hit_y,
  output logic [gdr_pkg::CODE_W-1:0]    hit_code,
  output logic [gdr_pkg::DIST_W-1:0]    perp_dist,
  output logic [gdr_pkg::LINE_W-1:0]    line_height,
  output logic [gdr_pkg::COL_W-1:0]     wall_top,
  output logic [gdr_pkg::SCR_W-1:0]     wall_bottom
);

  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = $clog2(MAX_SCREEN + 1);
  localparam int WLIM  = MAP_WIDTH + MAP_HEIGHT + 4;
  localparam int WCW   = $clog2(WLIM + 1);
  localparam int CW    = gdr_pkg::CW;
  localparam logic signed [CW-1:0] MW_S = CW'(MAP_WIDTH);
  localparam logic signed [CW-1:0] MH_S = CW'(MAP_HEIGHT);

  // configuration
  logic signed [gdr_pkg::DIR_W-1:0] cam_dir_x, cam_dir_y, plane_x, plane_y;
  logic [gdr_pkg::EYE_W-1:0]        eye_x, eye_y;
  logic [gdr_pkg::SCR_W-1:0]        screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_dir_x     <= gdr_pkg::RST_CAM_DIR_X;
      cam_dir_y     <= gdr_pkg::RST_CAM_DIR_Y;
      plane_x       <= gdr_pkg::RST_PLANE_X;
      plane_y       <= gdr_pkg::RST_PLANE_Y;
      eye_x         <= gdr_pkg::RST_EYE_X;
      eye_y         <= gdr_pkg::RST_EYE_Y;
      screen_width  <= gdr_pkg::RST_WIDTH;
      screen_height <= gdr_pkg::RST_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        gdr_pkg::CFG_CAM_DIR_X: cam_dir_x     <= cfg_data[15:0];
        gdr_pkg::CFG_CAM_DIR_Y: cam_dir_y     <= cfg_data[15:0];
        gdr_pkg::CFG_PLANE_X:   plane_x       <= cfg_data[15:0];
        gdr_pkg::CFG_PLANE_Y:   plane_y       <= cfg_data[15:0];
        gdr_pkg::CFG_EYE_X:     eye_x         <= cfg_data;
        gdr_pkg::CFG_EYE_Y:     eye_y         <= cfg_data;
        gdr_pkg::CFG_WIDTH:     screen_width  <= cfg_data[11:0];
        gdr_pkg::CFG_HEIGHT:    screen_height <= cfg_data[11:0];
        default:                eye_x         <= eye_x;
      endcase
    end
  end

  logic [SW-1:0] w_c, h_c;
  always_comb begin
    if (screen_width == '0) w_c = SW'(1);
    else if (screen_width > MAX_SCREEN) w_c = SW'(MAX_SCREEN);
    else w_c = SW'(screen_width);
    if (screen_height > MAX_SCREEN) h_c = SW'(MAX_SCREEN);
    else h_c = SW'(screen_height);
  end

  // map memory and clearing sweep
  logic [CELL_BITS-1:0] map_mem [DEPTH];
  logic [CELL_BITS-1:0] rdata;
  logic [AW-1:0]        clr_addr, waddr, raddr;
  logic [CELL_BITS-1:0] wdata;
  logic                 we, item_write;

  assign item_write = cmd.accept && in_valid && !action &&
                      (cell_x < MAP_WIDTH) && (cell_y < MAP_HEIGHT);

  always_comb begin
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = item_write;
      waddr = {YW'(cell_y), XW'(cell_x)};
      wdata = CELL_BITS'(cell_code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) map_mem[waddr] <= wdata;
    rdata <= map_mem[raddr];
  end

  // divider operands
  logic [gdr_pkg::DIV_NW-1:0] div_num, quo;
  logic [gdr_pkg::DIV_DW-1:0] div_den;
  logic                       div_done;

  logic [gdr_pkg::COL_W-1:0]         col_r;
  logic signed [gdr_pkg::DIR_W-1:0]  cam_r;
  logic signed [31:0]                prod_x, prod_y;
  logic signed [gdr_pkg::RAY_W-1:0]  ray_x, ray_y;
  logic [gdr_pkg::AD_W-1:0]          ad_x, ad_y;
  logic                              neg_x, neg_y;
  logic [gdr_pkg::DELTA_W-1:0]       delta_x, delta_y;
  logic [gdr_pkg::RUN_W-1:0]         run_x, run_y;
  logic signed [CW-1:0]              cx, cy, nx, ny;
  logic                              side_r, outside, outside_n, less;
  logic [WCW-1:0]                    walk_cnt;
  logic [gdr_pkg::CODE_W-1:0]        code_r;
  logic [gdr_pkg::DIST_W-1:0]        dist_r;
  logic [gdr_pkg::LINE_W-1:0]        lh;

  // distance numerator for the side that was crossed
  logic signed [gdr_pkg::NUM_W-1:0] cell_ext, num_s, num_abs;
  logic [gdr_pkg::EYE_W-1:0]        eye_sel;
  logic                             neg_sel;
  logic [gdr_pkg::AD_W-1:0]         ad_sel;

  always_comb begin
    cell_ext = side_r ? gdr_pkg::NUM_W'(cy) : gdr_pkg::NUM_W'(cx);
    eye_sel  = side_r ? eye_y : eye_x;
    neg_sel  = side_r ? neg_y : neg_x;
    ad_sel   = side_r ? ad_y : ad_x;
    num_s    = (cell_ext <<< 12) - $signed(gdr_pkg::NUM_W'(eye_sel))
             + (neg_sel ? gdr_pkg::NUM_W'(4096) : gdr_pkg::NUM_W'(0));
    num_abs  = num_s[gdr_pkg::NUM_W-1] ? -num_s : num_s;
  end

  always_comb begin
    case (cmd.div_op)
      gdr_pkg::DIV_CAM: begin
        div_num = gdr_pkg::DIV_NW'(col_r) << 15;
        div_den = gdr_pkg::DIV_DW'(w_c);
      end
      gdr_pkg::DIV_DX: begin
        div_num = gdr_pkg::DIV_NW'(1) << 26;
        div_den = gdr_pkg::DIV_DW'(ad_x);
      end
      gdr_pkg::DIV_DY: begin
        div_num = gdr_pkg::DIV_NW'(1) << 26;
        div_den = gdr_pkg::DIV_DW'(ad_y);
      end
      gdr_pkg::DIV_DIST: begin
        div_num = gdr_pkg::DIV_NW'($unsigned(num_abs)) << 14;
        div_den = gdr_pkg::DIV_DW'(ad_sel);
      end
      gdr_pkg::DIV_LH: begin
        div_num = gdr_pkg::DIV_NW'(h_c) << 12;
        div_den = gdr_pkg::DIV_DW'(dist_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gdr_div #(
    .NW(gdr_pkg::DIV_NW),
    .DW(gdr_pkg::DIV_DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  // ray direction
  logic signed [gdr_pkg::RAY_W-1:0] ray_xn, ray_yn;
  assign ray_xn = gdr_pkg::RAY_W'(cam_dir_x) + gdr_pkg::RAY_W'(prod_x >>> 14);
  assign ray_yn = gdr_pkg::RAY_W'(cam_dir_y) + gdr_pkg::RAY_W'(prod_y >>> 14);
  assign ray_x  = ray_xn;
  assign ray_y  = ray_yn;

  // initial side distances
  logic [12:0] mx, my;
  logic [43:0] init_x, init_y;
  assign mx     = neg_x ? {1'b0, eye_x[11:0]} : 13'd4096 - {1'b0, eye_x[11:0]};
  assign my     = neg_y ? {1'b0, eye_y[11:0]} : 13'd4096 - {1'b0, eye_y[11:0]};
  assign init_x = mx * delta_x;
  assign init_y = my * delta_y;

  // one DDA step; x only when its side distance is strictly smaller
  assign less = run_x < run_y;
  always_comb begin
    nx = cx;
    ny = cy;
    if (less) nx = neg_x ? cx - CW'(1) : cx + CW'(1);
    else      ny = neg_y ? cy - CW'(1) : cy + CW'(1);
    outside_n = (nx < 0) || (nx >= MW_S) || (ny < 0) || (ny >= MH_S);
    raddr     = {YW'(ny), XW'(nx)};
  end

  logic wall_seen;
  assign wall_seen = !outside && (rdata != '0);

  logic [15:0] cam_min;
  assign cam_min = (quo > gdr_pkg::DIV_NW'(32768)) ? 16'd32768 : quo[15:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_valid && action) col_r <= column;
    if (div_done) begin
      case (cmd.div_op)
        gdr_pkg::DIV_CAM:  cam_r <= cam_min - 16'd16384;
        gdr_pkg::DIV_DX:   delta_x <= (ad_x == '0) ? gdr_pkg::STEP_SAT
                                                   : gdr_pkg::DELTA_W'(quo);
        gdr_pkg::DIV_DY:   delta_y <= (ad_y == '0) ? gdr_pkg::STEP_SAT
                                                   : gdr_pkg::DELTA_W'(quo);
        gdr_pkg::DIV_DIST: begin
          if (ad_sel == '0 || quo > gdr_pkg::DIV_NW'(gdr_pkg::DIST_MAX))
            dist_r <= gdr_pkg::DIST_MAX;
          else
            dist_r <= gdr_pkg::DIST_W'(quo);
        end
        gdr_pkg::DIV_LH: begin
          if (dist_r == '0 || quo > gdr_pkg::DIV_NW'(gdr_pkg::LINE_MAX))
            lh <= gdr_pkg::LINE_MAX;
          else
            lh <= gdr_pkg::LINE_W'(quo);
        end
        default: lh <= lh;
      endcase
    end
    if (cmd.ray_mul) begin
      prod_x <= plane_x * cam_r;
      prod_y <= plane_y * cam_r;
    end
    if (cmd.ray_sum) begin
      neg_x <= ray_x < 0;
      neg_y <= ray_y < 0;
      ad_x  <= gdr_pkg::AD_W'(ray_x < 0 ? -ray_x : ray_x);
      ad_y  <= gdr_pkg::AD_W'(ray_y < 0 ? -ray_y : ray_y);
    end
    if (cmd.setup) begin
      run_x    <= gdr_pkg::RUN_W'(init_x >> 12);
      run_y    <= gdr_pkg::RUN_W'(init_y >> 12);
      cx       <= CW'(eye_x[17:12]);
      cy       <= CW'(eye_y[17:12]);
      side_r   <= 1'b0;
      walk_cnt <= '0;
    end
    if (cmd.step) begin
      if (less) run_x <= run_x + gdr_pkg::RUN_W'(delta_x);
      else      run_y <= run_y + gdr_pkg::RUN_W'(delta_y);
      cx       <= nx;
      cy       <= ny;
      side_r   <= !less;
      outside  <= outside_n;
      walk_cnt <= walk_cnt + 1'b1;
    end
    if (cmd.check) code_r <= wall_seen ? gdr_pkg::CODE_W'(rdata) : gdr_pkg::BORDER_CODE;
  end

  // span and result register
  logic signed [17:0]  t_top, t_bot;
  logic [CW-1:0]       hx_c, hy_c;
  logic                load;

  assign t_top = 18'(h_c >> 1) - 18'(lh >> 1);
  assign t_bot = 18'(h_c >> 1) + 18'(lh >> 1);
  assign hx_c  = (cx < 0) ? '0 : (cx >= MW_S) ? MW_S - CW'(1) : cx;
  assign hy_c  = (cy < 0) ? '0 : (cy >= MH_S) ? MH_S - CW'(1) : cy;
  assign load  = cmd.finish && st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_column  <= col_r;
      side        <= side_r;
      hit_x       <= gdr_pkg::CELLI_W'(hx_c);
      hit_y       <= gdr_pkg::CELLI_W'(hy_c);
      hit_code    <= code_r;
      perp_dist   <= dist_r;
      line_height <= lh;
      wall_top    <= t_top[17] ? '0 : gdr_pkg::COL_W'(t_top);
      wall_bottom <= (t_bot >= 18'(h_c)) ? gdr_pkg::SCR_W'(h_c) : gdr_pkg::SCR_W'(t_bot);
    end
  end

  always_comb begin
    st.clear_last = &clr_addr;
    st.div_done   = div_done;
    st.walk_end   = outside || (rdata != '0) || (walk_cnt == WCW'(WLIM));
    st.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== sv/grid_dda_ray_caster_unit.sv =====
// Grid DDA ray caster: map store, column cast by DDA walk, wall span result.
//
// Input channel (in_valid/in_ready): action 0 writes one map cell from
// cell_x/cell_y/cell_code in the accepting cycle and gives no result; action 1
// casts the screen column on column and gives exactly one result beat.
// Output channel (out_valid/out_ready) carries side, hit cell, code, perpendicular
// distance, slice height and the wall span clamped to the screen.
// Registers are written on cfg_write with cfg_index/cfg_data; the user must write
// them only while idle, the block itself does not enforce it. A cast runs five
// divisions on one shared restoring divider (one quotient bit a cycle) and walks
// the DDA with a STEP and a CHECK state per step, set by the registered map read.
// A write beat leaves the block idle, ready for the next beat. One cast is worked
// on at a time.
// After reset the map is swept to zero, one cell a cycle over all 2^(XW+YW) cells
// (4096 for a 64 x 64 map); in_ready stays low until the sweep ends.
// The result sits in an output register; a stalled receiver holds it, and the
// next cast waits at its end until that register is free; no beat of either
// kind is taken while a cast is in progress or waiting.
module grid_dda_ray_caster_unit #(
  parameter int MAP_WIDTH  = gdr_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = gdr_pkg::DEF_MAP_HEIGHT,
  parameter int MAX_SCREEN = gdr_pkg::DEF_MAX_SCREEN,
  parameter int CELL_BITS  = gdr_pkg::DEF_CELL_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [gdr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gdr_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [gdr_pkg::CELLI_W-1:0] cell_x,
  input  logic [gdr_pkg::CELLI_W-1:0] cell_y,
  input  logic [gdr_pkg::CODE_W-1:0]  cell_code,
  input  logic [gdr_pkg::COL_W-1:0]   column,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gdr_pkg::COL_W-1:0]   out_column,
  output logic                        side,
  output logic [gdr_pkg::CELLI_W-1:0] hit_x,
  output logic [gdr_pkg::CELLI_W-1:0] hit_y,
  output logic [gdr_pkg::CODE_W-1:0]  hit_code,
  output logic [gdr_pkg::DIST_W-1:0]  perp_dist,
  output logic [gdr_pkg::LINE_W-1:0]  line_height,
  output logic [gdr_pkg::COL_W-1:0]   wall_top,
  output logic [gdr_pkg::SCR_W-1:0]   wall_bottom
);

  gdr_pkg::gdr_cmd_t    cmd;
  gdr_pkg::gdr_status_t st;

  assign in_ready = cmd.accept;

  gdr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .action  (action),
    .st      (st),
    .cmd     (cmd)
  );

  gdr_datapath #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .MAX_SCREEN(MAX_SCREEN),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .action     (action),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_code  (cell_code),
    .column     (column),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_column (out_column),
    .side       (side),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_code   (hit_code),
    .perp_dist  (perp_dist),
    .line_height(line_height),
    .wall_top   (wall_top),
    .wall_bottom(wall_bottom)
  );

  // a cast beat takes the block out of idle
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action |=> !in_ready)
    else $error("in_ready still high after a cast beat");

  // divider results only turn up while a division is pending
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> cmd.div_op != gdr_pkg::DIV_NONE)
    else $error("divider finished with no division pending");

  // a result appears only from the finishing step of a cast
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result beat raised outside the finishing step");

endmodule

// ===== sim/grid_dda_ray_caster_unit_tb.sv =====
// Self-checking testbench of the grid DDA ray caster: directed table, then random phases.
`timescale 1ns / 100ps

module grid_dda_ray_caster_unit_tb;

  localparam int  MAPW = 64;
  localparam int  MAPH = 64;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  TAIL_CYCLES = 600;
  localparam bit  ACT_WRITE = 1'b0;
  localparam bit  ACT_CAST  = 1'b1;

  typedef enum logic [1:0] {ROW_WRITE, ROW_CAST, ROW_CFG} row_kind_t;

  typedef struct {
    logic [gdr_pkg::COL_W-1:0]   col;
    logic                        side;
    logic [gdr_pkg::CELLI_W-1:0] hx;
    logic [gdr_pkg::CELLI_W-1:0] hy;
    logic [gdr_pkg::CODE_W-1:0]  code;
    logic [gdr_pkg::DIST_W-1:0]  pdist;
    logic [gdr_pkg::LINE_W-1:0]  lh;
    logic [gdr_pkg::COL_W-1:0]   top;
    logic [gdr_pkg::SCR_W-1:0]   bot;
  } span_t;

  typedef struct {
    row_kind_t                   kind;
    logic [gdr_pkg::CELLI_W-1:0] cx;
    logic [gdr_pkg::CELLI_W-1:0] cy;
    logic [gdr_pkg::CODE_W-1:0]  code;
    logic [gdr_pkg::COL_W-1:0]   col;
    gdr_pkg::cfg_index_t         idx;
    logic [gdr_pkg::CFG_DW-1:0]  data;
    bit                          fixed;
    span_t                       want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [gdr_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [gdr_pkg::CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [gdr_pkg::CELLI_W-1:0] cell_x = '0, cell_y = '0;
  logic [gdr_pkg::CODE_W-1:0]  cell_code = '0;
  logic [gdr_pkg::COL_W-1:0]   column = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gdr_pkg::COL_W-1:0]   out_column;
  logic                        side;
  logic [gdr_pkg::CELLI_W-1:0] hit_x, hit_y;
  logic [gdr_pkg::CODE_W-1:0]  hit_code;
  logic [gdr_pkg::DIST_W-1:0]  perp_dist;
  logic [gdr_pkg::LINE_W-1:0]  line_height;
  logic [gdr_pkg::COL_W-1:0]   wall_top;
  logic [gdr_pkg::SCR_W-1:0]   wall_bottom;

  grid_dda_ray_caster_unit uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [gdr_pkg::CODE_W-1:0] map_mirror [0:MAPW*MAPH-1];
  longint dir_x, dir_y, pln_x, pln_y, pos_x, pos_y, scr_w, scr_h;
  span_t  spans_due[$];
  row_t   plan[$];
  int     errors = 0;
  int     cycles = 0;
  bit     long_hold_req = 0;
  bit     tx_busy_only = 0;   // no sender gaps
  bit     rx_always = 0;      // no receiver stalls

  function automatic longint sx16(logic [gdr_pkg::CFG_DW-1:0] v);
    return longint'($signed(v[15:0]));
  endfunction

  function automatic void apply_reg(gdr_pkg::cfg_index_t i, logic [gdr_pkg::CFG_DW-1:0] v);
    case (i)
      gdr_pkg::CFG_CAM_DIR_X: dir_x = sx16(v);
      gdr_pkg::CFG_CAM_DIR_Y: dir_y = sx16(v);
      gdr_pkg::CFG_PLANE_X:   pln_x = sx16(v);
      gdr_pkg::CFG_PLANE_Y:   pln_y = sx16(v);
      gdr_pkg::CFG_EYE_X:     pos_x = longint'(v);
      gdr_pkg::CFG_EYE_Y:     pos_y = longint'(v);
      gdr_pkg::CFG_WIDTH:     scr_w = longint'(v[gdr_pkg::SCR_W-1:0]);
      default:                scr_h = longint'(v[gdr_pkg::SCR_W-1:0]);
    endcase
  endfunction

  function automatic longint q14_floor(longint v);
    return (v >= 0) ? (v >>> 14) : -(((-v) + 16383) >>> 14);
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void ray_axis(input longint d, input longint e, output longint cidx,
                                   output longint stp, output longint gain,
                                   output longint run);
    longint fr;
    fr = e & 4095;
    cidx = e >>> 12;
    gain = (d == 0) ? (64'sd1 << 30) : clampl((64'sd1 << 26) / absl(d), 0, 64'sd1 << 30);
    stp = (d < 0) ? -1 : 1;
    run = (d < 0) ? ((fr * gain) >>> 12) : (((4096 - fr) * gain) >>> 12);
  endfunction

  function automatic span_t cast_column(logic [gdr_pkg::COL_W-1:0] c);
    span_t  r;
    longint w, h, cam, rx, ry, xc, xs, xg, xr, yc, ys, yg, yr, num, ad, pd, lh, half, top, bot;
    bit     hit;
    int     sd, n;
    logic [gdr_pkg::CODE_W-1:0] code;
    w = clampl(scr_w, 1, 2048);
    h = clampl(scr_h, 0, 2048);
    cam = (2 * longint'(c) * 16384) / w;
    if (cam > 32768) cam = 32768;
    cam -= 16384;
    rx = dir_x + q14_floor(pln_x * cam);
    ry = dir_y + q14_floor(pln_y * cam);
    ray_axis(rx, pos_x, xc, xs, xg, xr);
    ray_axis(ry, pos_y, yc, ys, yg, yr);
    hit = 0;
    sd = 0;
    code = gdr_pkg::BORDER_CODE;
    for (n = 0; n < MAPW + MAPH + 4 && !hit; n++) begin
      if (xr < yr) begin
        xr += xg; xc += xs; sd = 0;
      end else begin
        yr += yg; yc += ys; sd = 1;
      end
      if (xc < 0 || xc >= MAPW || yc < 0 || yc >= MAPH) begin
        hit = 1; code = gdr_pkg::BORDER_CODE;
      end else if (map_mirror[yc*MAPW + xc] != 0) begin
        hit = 1; code = map_mirror[yc*MAPW + xc];
      end
    end
    if (!hit) code = gdr_pkg::BORDER_CODE;
    if (sd) begin
      num = yc * 4096 - pos_y + ((ys < 0) ? 4096 : 0); ad = absl(ry);
    end else begin
      num = xc * 4096 - pos_x + ((xs < 0) ? 4096 : 0); ad = absl(rx);
    end
    pd = (ad == 0) ? 4194303 : clampl((absl(num) * 16384) / ad, 0, 4194303);
    lh = (pd == 0) ? 65535 : clampl((h * 4096) / pd, 0, 65535);
    half = h / 2;
    top = half - lh / 2;
    if (top < 0) top = 0;
    bot = half + lh / 2;
    if (bot >= h) bot = h;
    r.col = c;
    r.side = sd[0];
    r.hx = gdr_pkg::CELLI_W'(clampl(xc, 0, MAPW-1));
    r.hy = gdr_pkg::CELLI_W'(clampl(yc, 0, MAPH-1));
    r.code = code;
    r.pdist = gdr_pkg::DIST_W'(pd);
    r.lh = gdr_pkg::LINE_W'(lh);
    r.top = gdr_pkg::COL_W'(top);
    r.bot = gdr_pkg::SCR_W'(bot);
    return r;
  endfunction

  task automatic add_row(row_kind_t k, int a, int b, int cd, int cl, bit fx, span_t wv);
    row_t r;
    r.kind = k;
    r.cx = gdr_pkg::CELLI_W'(a);
    r.cy = gdr_pkg::CELLI_W'(b);
    r.code = gdr_pkg::CODE_W'(cd);
    r.col = gdr_pkg::COL_W'(cl);
    r.idx = gdr_pkg::cfg_index_t'(a);
    r.data = gdr_pkg::CFG_DW'(b);
    r.fixed = fx;
    r.want = wv;
    plan.push_back(r);
  endtask

  task automatic set_reg(gdr_pkg::cfg_index_t i, logic [gdr_pkg::CFG_DW-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= i;
    cfg_data <= v;
    apply_reg(i, v);
    @(posedge clk);
  endtask

  // block is idle once every cast has come back; a write leaves it idle
  task automatic drain();
    in_valid <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_beat(bit act, logic [gdr_pkg::CELLI_W-1:0] x,
                           logic [gdr_pkg::CELLI_W-1:0] y,
                           logic [gdr_pkg::CODE_W-1:0] cd, logic [gdr_pkg::COL_W-1:0] cl,
                           bit fx, span_t wv);
    int gap;
    gap = 0;
    if (!tx_busy_only) begin
      gap = $urandom_range(0, 9);
      gap = (gap < 6) ? 0 : ((gap < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    cell_x <= x;
    cell_y <= y;
    cell_code <= cd;
    column <= cl;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_WRITE)
      map_mirror[int'(y)*MAPW + int'(x)] = cd;
    else
      spans_due.push_back(fx ? wv : cast_column(cl));
  endtask

  function automatic logic [gdr_pkg::CFG_DW-1:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 18'h0;
      1: return 18'h08000;
      2: return 18'h07FFF;
      3: return gdr_pkg::CFG_DW'($urandom_range(0, 32767));
      default: return gdr_pkg::CFG_DW'($urandom);
    endcase
  endfunction

  function automatic logic [gdr_pkg::CFG_DW-1:0] pick_screen();
    case ($urandom_range(0, 9))
      0: return 18'd0;
      1: return 18'd1;
      2: return 18'd2048;
      3: return 18'hFFF;
      4: return 18'd640;
      default: return gdr_pkg::CFG_DW'($urandom_range(1, 2048)) |
                      (gdr_pkg::CFG_DW'($urandom_range(0, 63)) << 12);
    endcase
  endfunction

  // receiver: random stalls, an occasional long hold, and the result check
  int hold_cnt = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      if (spans_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, column %0d", $time, out_column);
      end else begin
        span_t e;
        e = spans_due.pop_front();
        if (out_column !== e.col) begin errors++;
          $display("%0t: out_column exp %0d got %0d", $time, e.col, out_column); end
        if (side !== e.side) begin errors++;
          $display("%0t: side exp %0d got %0d", $time, e.side, side); end
        if (hit_x !== e.hx) begin errors++;
          $display("%0t: hit_x exp %0d got %0d", $time, e.hx, hit_x); end
        if (hit_y !== e.hy) begin errors++;
          $display("%0t: hit_y exp %0d got %0d", $time, e.hy, hit_y); end
        if (hit_code !== e.code) begin errors++;
          $display("%0t: hit_code exp %0d got %0d", $time, e.code, hit_code); end
        if (perp_dist !== e.pdist) begin errors++;
          $display("%0t: perp_dist exp %0d got %0d", $time, e.pdist, perp_dist); end
        if (line_height !== e.lh) begin errors++;
          $display("%0t: line_height exp %0d got %0d", $time, e.lh, line_height); end
        if (wall_top !== e.top) begin errors++;
          $display("%0t: wall_top exp %0d got %0d", $time, e.top, wall_top); end
        if (wall_bottom !== e.bot) begin errors++;
          $display("%0t: wall_bottom exp %0d got %0d", $time, e.bot, wall_bottom); end
      end
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 3000;
      out_ready <= 1'b0;
    end else if (rx_always) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_cnt = $urandom_range(10, 80);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    span_t nil, w0, w1;
    int ph, k;
    foreach (map_mirror[i]) map_mirror[i] = '0;
    dir_x = 16384; dir_y = 0; pln_x = 0; pln_y = 10813;
    pos_x = 8192; pos_y = 8192; scr_w = 640; scr_h = 480;
    nil = '{default: '0};
    // empty map after reset: centre ray runs to the east border
    w0 = '{col: 320, side: 0, hx: 63, hy: 2, code: 15, pdist: 253952, lh: 7, top: 237,
           bot: 243};
    w1 = '{col: 320, side: 0, hx: 5, hy: 2, code: 9, pdist: 12288, lh: 160, top: 160,
           bot: 320};
    add_row(ROW_CAST, 0, 0, 0, 320, 1, w0);
    add_row(ROW_WRITE, 5, 2, 9, 0, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 320, 1, w1);
    add_row(ROW_CAST, 0, 0, 0, 0, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 639, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 2047, 0, nil);       // column beyond width
    add_row(ROW_WRITE, 0, 0, 15, 0, 0, nil);
    add_row(ROW_WRITE, 63, 63, 1, 0, 0, nil);
    add_row(ROW_WRITE, 5, 2, 0, 0, 0, nil);
    // looking west from a cell edge into an adjacent wall: zero distance
    add_row(ROW_CFG, gdr_pkg::CFG_CAM_DIR_X, 18'h0C000, 0, 0, 0, nil);
    add_row(ROW_WRITE, 1, 2, 3, 0, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 320, 0, nil);
    // zero ray on both axes
    add_row(ROW_CFG, gdr_pkg::CFG_CAM_DIR_X, 0, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_PLANE_Y, 0, 0, 0, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 100, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_WIDTH, 0, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_HEIGHT, 0, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_CAM_DIR_Y, 18'h07FFF, 0, 0, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 5, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_WIDTH, 18'hFFF, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_HEIGHT, 18'hFFF, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_EYE_X, 18'h3FFFF, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_EYE_Y, 0, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_CAM_DIR_X, 18'h08000, 0, 0, 0, nil);
    add_row(ROW_CFG, gdr_pkg::CFG_PLANE_X, 18'h08000, 0, 0, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 2047, 0, nil);
    add_row(ROW_CAST, 0, 0, 0, 1023, 0, nil);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        set_reg(plan[i].idx, plan[i].data);
        cfg_write <= 1'b0;
      end else begin
        send_beat(plan[i].kind == ROW_CAST, plan[i].cx, plan[i].cy, plan[i].code,
                  plan[i].col, plan[i].fixed, plan[i].want);
      end
    end

    for (ph = 0; ph < 10; ph++) begin
      drain();
      tx_busy_only = (ph == 4);
      rx_always = (ph == 4);
      set_reg(gdr_pkg::CFG_CAM_DIR_X, pick_dir());
      set_reg(gdr_pkg::CFG_CAM_DIR_Y, pick_dir());
      set_reg(gdr_pkg::CFG_PLANE_X, pick_dir());
      set_reg(gdr_pkg::CFG_PLANE_Y, pick_dir());
      set_reg(gdr_pkg::CFG_EYE_X,
              ($urandom_range(0, 7) == 0) ? 18'h3FFFF : gdr_pkg::CFG_DW'($urandom));
      set_reg(gdr_pkg::CFG_EYE_Y,
              ($urandom_range(0, 7) == 0) ? 18'h0 : gdr_pkg::CFG_DW'($urandom));
      set_reg(gdr_pkg::CFG_WIDTH, pick_screen());
      set_reg(gdr_pkg::CFG_HEIGHT, pick_screen());
      cfg_write <= 1'b0;
      if (ph == 2) long_hold_req = 1;   // block fills and backs up its input
      for (k = 0; k < 115; k++) begin
        if ($urandom_range(0, 9) < 4)
          send_beat(ACT_WRITE, gdr_pkg::CELLI_W'($urandom), gdr_pkg::CELLI_W'($urandom),
                    ($urandom_range(0, 1) != 0) ? gdr_pkg::CODE_W'($urandom)
                                                : gdr_pkg::CODE_W'(0), '0, 0, nil);
        else
          send_beat(ACT_CAST, '0, '0, '0,
                    ($urandom_range(0, 3) == 0) ? gdr_pkg::COL_W'($urandom) :
                    gdr_pkg::COL_W'($urandom_range(0, int'(clampl(scr_w, 1, 2048)))),
                    0, nil);
      end
    end
    tx_busy_only = 0;
    rx_always = 0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && spans_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (spans_due.size() != 0)
        $display("%0t: %0d results never arrived", $time, spans_due.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
